/* src/tikd_pkg.sv */
// Package: shared types, codes and helpers for the terminal input key decoder.
`default_nettype none
package tikd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_CSI, PH_SS3, PH_UTF8, PH_PASTE
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE, SQ_RUN, SQ_FLUSH, SQ_DONE
  } seq_t;

  localparam logic [2:0] KIND_KEY       = 3'd0;
  localparam logic [2:0] KIND_CHAR      = 3'd1;
  localparam logic [2:0] KIND_PASTE     = 3'd2;
  localparam logic [2:0] KIND_PASTE_END = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd4;
  localparam logic [2:0] KIND_INVALID   = 3'd5;

  localparam logic [3:0] K_HOME   = 4'd4;
  localparam logic [3:0] K_END    = 4'd5;
  localparam logic [3:0] K_INSERT = 4'd6;
  localparam logic [3:0] K_DELETE = 4'd7;
  localparam logic [3:0] K_PGUP   = 4'd8;
  localparam logic [3:0] K_PGDN   = 4'd9;
  localparam logic [3:0] K_FUNC   = 4'd10;
  localparam logic [3:0] K_ESCAPE = 4'd11;
  localparam logic [3:0] K_ENTER  = 4'd12;
  localparam logic [3:0] K_TAB    = 4'd13;
  localparam logic [3:0] K_BKSP   = 4'd14;

  localparam logic [3:0] M_ALT  = 4'd2;
  localparam logic [3:0] M_CTRL = 4'd4;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [2:0] P200_FAIL = 3'd4;
  localparam logic [2:0] MAX_RES  = 3'd6;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  key_code;
    logic [3:0]  fkey_num;
    logic [3:0]  modifiers;
    logic [31:0] text_bytes;
    logic [2:0]  text_length;
  } res_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  key_code;
    logic [3:0]  fkey_num;
    logic [3:0]  modifiers;
    logic [31:0] text_bytes;
    logic [2:0]  text_length;
    logic        last;
  } out_t;

  // decoder state carried between bytes
  typedef struct packed {
    phase_t          phase;
    logic [5:0][7:0] held;
    logic [2:0]      hc;
    logic [2:0]      uel;
    logic [1:0][30:0] pval;
    logic [1:0][1:0] pflag;   // bit0 digit seen, bit1 malformed
    logic [1:0]      pidx;
    logic [2:0]      p200;
    logic [2:0]      pem;
  } dstate_t;

  // side effects of one decode step besides a single result
  typedef struct packed {
    logic [1:0]      rep_n;
    logic [2:0][7:0] rep;
    logic [2:0]      fl_m;
    logic            fl_bv;
    logic [7:0]      fl_b;
  } stepx_t;

  function automatic logic [7:0] paste_seq(input logic [2:0] k);
    case (k)
      3'd0:    paste_seq = 8'h1b;
      3'd1:    paste_seq = 8'h5b;
      3'd2:    paste_seq = 8'h32;
      3'd3:    paste_seq = 8'h30;
      3'd4:    paste_seq = 8'h31;
      default: paste_seq = 8'h7e;
    endcase
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [3:0] key,
                                  input logic [3:0] fn, input logic [3:0] mods,
                                  input logic [31:0] text, input logic [2:0] len);
    res_t r;
    r.event_kind      = kind;
    r.key_code        = key;
    r.fkey_num        = fn;
    r.modifiers       = mods;
    r.text_bytes      = text;
    r.text_length     = len;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/tikd_step.sv */
// Byte decode unit: one input byte or timeout against the decoder state.
`default_nettype none
module tikd_step (
  input  wire                   tick,
  input  wire  [7:0]            b,
  input  tikd_pkg::dstate_t     s,
  output tikd_pkg::dstate_t     ns,
  output logic                  res_v,
  output tikd_pkg::res_t        res,
  output tikd_pkg::stepx_t      sx
);
  import tikd_pkg::*;

  logic [30:0] first, sec;
  logic [3:0]  mods;
  logic [3:0]  cc;
  logic        cc_ok;
  logic [34:0] v;
  logic        i;
  logic [5:0][7:0] hw;
  logic [2:0]  nhc, m, ln;
  logic        ok;
  logic [31:0] txt;

  always_comb begin
    ns    = s;
    res_v = 1'b0;
    res   = '0;
    sx    = '0;
    first = (s.pflag[0] == 2'b01) ? s.pval[0] : 31'd0;
    sec   = (s.pflag[1] == 2'b01) ? s.pval[1] : 31'd0;
    mods  = (s.pidx != 2'd0 && sec > 31'd1) ? 4'(sec - 31'd1) : 4'd0;
    cc_ok = 1'b1;
    case (b)
      8'h41:   cc = 4'd0;
      8'h42:   cc = 4'd1;
      8'h43:   cc = 4'd2;
      8'h44:   cc = 4'd3;
      8'h48:   cc = K_HOME;
      8'h46:   cc = K_END;
      default: begin
        cc    = 4'd0;
        cc_ok = 1'b0;
      end
    endcase
    i   = s.pidx[0];
    v   = ({4'd0, s.pval[i]} << 3) + ({4'd0, s.pval[i]} << 1) + {31'd0, b[3:0]};
    hw  = s.held;
    for (int j = 0; j < 6; j++) begin
      if (3'(j) == s.hc) begin
        hw[j] = b;
      end
    end
    nhc = s.hc + 3'd1;
    ok  = 1'b1;
    txt = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < s.uel) begin
        txt[8*j +: 8] = hw[j];
        if (j > 0 && hw[j][7:6] != 2'b10) begin
          ok = 1'b0;
        end
      end
    end
    m  = (s.pem > 3'd5) ? 3'd0 : s.pem;
    ln = 3'd0;

    if (tick) begin
      if (s.phase == PH_ESC) begin
        ns.phase = PH_IDLE;
        res_v    = 1'b1;
        res      = mk_res(KIND_KEY, K_ESCAPE, 4'd0, 4'd0, 32'd0, 3'd0);
      end
    end else begin
      case (s.phase)
        PH_ESC: begin
          ns.phase = PH_IDLE;
          if (b == 8'h5b) begin
            ns.phase = PH_CSI;
            ns.pval  = '0;
            ns.pflag = '0;
            ns.pidx  = 2'd0;
            ns.p200  = 3'd0;
          end else if (b == 8'h4f) begin
            ns.phase = PH_SS3;
          end else if (b >= 8'h20 && b <= 8'h7e) begin
            res_v = 1'b1;
            res   = mk_res(KIND_CHAR, 4'd0, 4'd0, M_ALT, {24'd0, b}, 3'd1);
          end else begin
            res_v = 1'b1;
            res   = mk_res(KIND_UNKNOWN, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
          end
        end
        PH_CSI: begin
          if (b >= 8'h40 && b <= 8'h7e) begin
            ns.phase = PH_IDLE;
            res_v    = 1'b1;
            res      = mk_res(KIND_UNKNOWN, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
            if (s.p200 == 3'd3 && b == 8'h7e) begin
              ns.phase = PH_PASTE;
              ns.pem   = 3'd0;
              res_v    = 1'b0;
            end else if (b == 8'h7e) begin
              if (first == 31'd1 || first == 31'd7)
                res = mk_res(KIND_KEY, K_HOME, 4'd0, mods, 32'd0, 3'd0);
              else if (first == 31'd2)
                res = mk_res(KIND_KEY, K_INSERT, 4'd0, mods, 32'd0, 3'd0);
              else if (first == 31'd3)
                res = mk_res(KIND_KEY, K_DELETE, 4'd0, mods, 32'd0, 3'd0);
              else if (first == 31'd4 || first == 31'd8)
                res = mk_res(KIND_KEY, K_END, 4'd0, mods, 32'd0, 3'd0);
              else if (first == 31'd5)
                res = mk_res(KIND_KEY, K_PGUP, 4'd0, mods, 32'd0, 3'd0);
              else if (first == 31'd6)
                res = mk_res(KIND_KEY, K_PGDN, 4'd0, mods, 32'd0, 3'd0);
              else if (first >= 31'd11 && first <= 31'd15)
                res = mk_res(KIND_KEY, K_FUNC, 4'(first - 31'd10), mods, 32'd0, 3'd0);
              else if (first >= 31'd17 && first <= 31'd21)
                res = mk_res(KIND_KEY, K_FUNC, 4'(first - 31'd11), mods, 32'd0, 3'd0);
              else if (first == 31'd23 || first == 31'd24)
                res = mk_res(KIND_KEY, K_FUNC, 4'(first - 31'd12), mods, 32'd0, 3'd0);
            end else if (cc_ok) begin
              res = mk_res(KIND_KEY, cc, 4'd0, mods, 32'd0, 3'd0);
            end
          end else begin
            if (s.p200 < 3'd3 && b == ((s.p200 == 3'd0) ? 8'h32 : 8'h30))
              ns.p200 = s.p200 + 3'd1;
            else
              ns.p200 = P200_FAIL;
            if (b == 8'h3b) begin
              if (s.pidx < 2'd2) ns.pidx = s.pidx + 2'd1;
            end else if (s.pidx < 2'd2) begin
              if (b >= 8'h30 && b <= 8'h39) begin
                ns.pflag[i][0] = 1'b1;
                if (v > 35'h7fffffff) ns.pflag[i][1] = 1'b1;
                else                  ns.pval[i] = v[30:0];
              end else begin
                ns.pflag[i][1] = 1'b1;
              end
            end
          end
        end
        PH_SS3: begin
          ns.phase = PH_IDLE;
          res_v    = 1'b1;
          if (cc_ok)
            res = mk_res(KIND_KEY, cc, 4'd0, 4'd0, 32'd0, 3'd0);
          else if (b >= 8'h50 && b <= 8'h53)
            res = mk_res(KIND_KEY, K_FUNC, 4'(b - 8'h4f), 4'd0, 32'd0, 3'd0);
          else
            res = mk_res(KIND_UNKNOWN, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
        end
        PH_UTF8: begin
          if (s.hc >= 3'd6 || s.uel > 3'd4 || s.uel < 3'd2) begin
            ns.phase = PH_IDLE;
            ns.hc    = 3'd0;
          end else begin
            ns.held = hw;
            if (nhc < s.uel) begin
              ns.hc = nhc;
            end else begin
              ns.phase = PH_IDLE;
              ns.hc    = 3'd0;
              res_v    = 1'b1;
              if (ok) begin
                res = mk_res(KIND_CHAR, 4'd0, 4'd0, 4'd0, txt, s.uel);
              end else begin
                res      = mk_res(KIND_INVALID, 4'd0, 4'd0, 4'd0, {24'd0, hw[0]}, 3'd1);
                sx.rep_n = 2'(s.uel - 3'd1);
                sx.rep   = {hw[3], hw[2], hw[1]};
              end
            end
          end
        end
        PH_PASTE: begin
          if (b == paste_seq(m)) begin
            if (m == 3'd5) begin
              res_v    = 1'b1;
              res      = mk_res(KIND_PASTE_END, 4'd0, 4'd0, 4'd0, 32'd0, 3'd0);
              ns.phase = PH_IDLE;
              ns.pem   = 3'd0;
            end else begin
              ns.pem = m + 3'd1;
            end
          end else begin
            ns.pem = (b == CH_ESC) ? 3'd1 : 3'd0;
            if (m != 3'd0) begin
              sx.fl_m  = m;
              sx.fl_bv = (b != CH_ESC);
              sx.fl_b  = b;
            end else if (b != CH_ESC) begin
              res_v = 1'b1;
              res   = mk_res(KIND_PASTE, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
            end
          end
        end
        default: begin
          ns.phase = PH_IDLE;
          if (b == CH_ESC) begin
            ns.phase = PH_ESC;
          end else if (b == 8'h0d || b == 8'h0a) begin
            res_v = 1'b1;
            res   = mk_res(KIND_KEY, K_ENTER, 4'd0, 4'd0, 32'd0, 3'd0);
          end else if (b == 8'h09) begin
            res_v = 1'b1;
            res   = mk_res(KIND_KEY, K_TAB, 4'd0, 4'd0, 32'd0, 3'd0);
          end else if (b == 8'h7f || b == 8'h08) begin
            res_v = 1'b1;
            res   = mk_res(KIND_KEY, K_BKSP, 4'd0, 4'd0, 32'd0, 3'd0);
          end else if (b >= 8'd1 && b <= 8'd26) begin
            res_v = 1'b1;
            res   = mk_res(KIND_CHAR, 4'd0, 4'd0, M_CTRL, {24'd0, b + 8'h60}, 3'd1);
          end else if (!b[7]) begin
            res_v = 1'b1;
            res   = mk_res(KIND_CHAR, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
          end else begin
            if (b[7:5] == 3'b110)       ln = 3'd2;
            else if (b[7:4] == 4'b1110) ln = 3'd3;
            else if (b[7:3] == 5'b11110) ln = 3'd4;
            if (ln == 3'd0) begin
              res_v = 1'b1;
              res   = mk_res(KIND_INVALID, 4'd0, 4'd0, 4'd0, {24'd0, b}, 3'd1);
            end else begin
              ns.held[0] = b;
              ns.hc      = 3'd1;
              ns.uel     = ln;
              ns.phase   = PH_UTF8;
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/terminal_input_key_decoder.sv */
// Top level: request sequencer, replay queue and result register around the byte decoder.
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_data  (operation, byte_in)
// out     | output    | out_valid/out_ready | out_data (event fields, last)
//
// A request is accepted, then each byte goes through the shared decode unit while the
// output is free; the sequencer then finds the replay queue empty and releases the
// final result. A bad UTF-8 tail is replayed one byte a cycle while the output is free,
// and a paste-end mismatch flushes its held bytes one at a time.
// Results sit one deep in pend so the final one can be flagged last; the sequencer
// stalls while the output register is full. rst_n is synchronous; held bytes not reset.
module terminal_input_key_decoder (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  tikd_pkg::in_t      in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output tikd_pkg::out_t     out_data
);
  import tikd_pkg::*;

  seq_t            st_r, st_nxt;
  dstate_t         ds_r, ds_nxt, ds_step;
  logic [2:0][7:0] q_r, q_nxt;
  logic [1:0]      qn_r, qn_nxt;
  logic            tick_r, tick_nxt;
  logic            pend_v_r, pend_v_nxt;
  res_t            pend_r, pend_nxt;
  logic            out_v_r, out_v_nxt;
  out_t            out_r, out_nxt;
  logic [2:0]      ecnt_r, ecnt_nxt;
  logic [2:0]      fl_k_r, fl_k_nxt, fl_m_r, fl_m_nxt;
  logic            fl_bv_r, fl_bv_nxt;
  logic [7:0]      fl_b_r, fl_b_nxt;

  logic            st_res_v;
  res_t            st_res;
  stepx_t          sx;
  logic            can_push, go, nv, fl_more, fl_left;
  res_t            nr;
  logic [2:0][7:0] rem;
  logic [1:0]      k;

  tikd_step u_step (
    .tick  (tick_r),
    .b     (q_r[0]),
    .s     (ds_r),
    .ns    (ds_step),
    .res_v (st_res_v),
    .res   (st_res),
    .sx    (sx)
  );

  assign in_ready  = (st_r == SQ_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign can_push  = !out_v_r || out_ready;
  assign fl_more   = (fl_k_r < fl_m_r) || fl_bv_r;
  // anything left after the current flush byte
  assign fl_left   = (fl_k_r < fl_m_r) ? ((fl_k_r + 3'd1 < fl_m_r) || fl_bv_r) : 1'b0;

  always_comb begin
    nr = st_res;
    nv = st_res_v;
    if (st_r == SQ_FLUSH) begin
      nr = mk_res(KIND_PASTE, 4'd0, 4'd0, 4'd0,
                  {24'd0, (fl_k_r < fl_m_r) ? paste_seq(fl_k_r) : fl_b_r}, 3'd1);
      nv = fl_more;
    end
    nv = nv && (ecnt_r < MAX_RES);
    go = !nv || !pend_v_r || can_push;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      SQ_IDLE:  if (in_valid) st_nxt = SQ_RUN;
      SQ_RUN: begin
        if (qn_r == 2'd0) st_nxt = SQ_DONE;
        else if (go && sx.fl_m != 3'd0) st_nxt = SQ_FLUSH;
      end
      SQ_FLUSH: if (!fl_more || (go && !fl_left)) st_nxt = SQ_RUN;
      SQ_DONE:  if (!pend_v_r || can_push) st_nxt = SQ_IDLE;
      default:  st_nxt = SQ_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ds_nxt     = ds_r;
    q_nxt      = q_r;
    qn_nxt     = qn_r;
    tick_nxt   = tick_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    ecnt_nxt   = ecnt_r;
    fl_k_nxt   = fl_k_r;
    fl_m_nxt   = fl_m_r;
    fl_bv_nxt  = fl_bv_r;
    fl_b_nxt   = fl_b_r;
    rem        = {8'd0, q_r[2], q_r[1]};
    k          = 2'd0;
    case (st_r)
      SQ_IDLE: begin
        if (in_valid) begin
          q_nxt[0] = in_data.byte_in;
          qn_nxt   = 2'd1;
          tick_nxt = in_data.operation;
          ecnt_nxt = 3'd0;
        end
      end
      SQ_RUN, SQ_FLUSH: begin
        if (go && (st_r == SQ_FLUSH || qn_r != 2'd0)) begin
          if (st_r == SQ_RUN) begin
            ds_nxt = ds_step;
            for (int j = 0; j < 3; j++) begin
              k = 2'(j) - sx.rep_n;
              q_nxt[j] = (2'(j) < sx.rep_n) ? sx.rep[j] : rem[k];
            end
            qn_nxt    = qn_r - 2'd1 + sx.rep_n;
            fl_k_nxt  = 3'd0;
            fl_m_nxt  = sx.fl_m;
            fl_bv_nxt = sx.fl_bv;
            fl_b_nxt  = sx.fl_b;
          end else if (fl_k_r < fl_m_r) begin
            fl_k_nxt = fl_k_r + 3'd1;
          end else begin
            fl_bv_nxt = 1'b0;
          end
          if (nv) begin
            ecnt_nxt = ecnt_r + 3'd1;
            if (pend_v_r) begin
              out_v_nxt = 1'b1;
              out_nxt   = {pend_r, 1'b0};
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = nr;
          end
        end
      end
      SQ_DONE: begin
        if (pend_v_r && can_push) begin
          out_v_nxt  = 1'b1;
          out_nxt    = {pend_r, 1'b1};
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ds_r.held       <= ds_nxt.held;   // no reset, written before read
    if (!rst_n) begin
      st_r          <= SQ_IDLE;
      ds_r.phase    <= PH_IDLE;
      ds_r.hc       <= '0;
      ds_r.uel      <= '0;
      ds_r.pval     <= '0;
      ds_r.pflag    <= '0;
      ds_r.pidx     <= '0;
      ds_r.p200     <= '0;
      ds_r.pem      <= '0;
      qn_r          <= '0;
      pend_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
      ecnt_r        <= '0;
      fl_k_r        <= '0;
      fl_m_r        <= '0;
      fl_bv_r       <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      ds_r.phase    <= ds_nxt.phase;
      ds_r.hc       <= ds_nxt.hc;
      ds_r.uel      <= ds_nxt.uel;
      ds_r.pval     <= ds_nxt.pval;
      ds_r.pflag    <= ds_nxt.pflag;
      ds_r.pidx     <= ds_nxt.pidx;
      ds_r.p200     <= ds_nxt.p200;
      ds_r.pem      <= ds_nxt.pem;
      qn_r          <= qn_nxt;
      pend_v_r      <= pend_v_nxt;
      out_v_r       <= out_v_nxt;
      ecnt_r        <= ecnt_nxt;
      fl_k_r        <= fl_k_nxt;
      fl_m_r        <= fl_m_nxt;
      fl_bv_r       <= fl_bv_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    tick_r    <= tick_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    fl_b_r    <= fl_b_nxt;
  end

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("pending result while idle");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qn_r != 2'd3 || st_r != SQ_IDLE)
    else $error("replay queue not drained at idle");
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= MAX_RES)
    else $error("result count over limit");
  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_r == SQ_RUN)
    else $error("request accepted without starting");
`endif

endmodule
`default_nettype wire

/* tb/tb_terminal_input_key_decoder.sv */
// Testbench for the terminal input key decoder: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module tb_terminal_input_key_decoder;
  import tikd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  // decoder phases for the predictor
  typedef enum int {
    DP_IDLE, DP_ESC, DP_CSI, DP_SS3, DP_UTF8, DP_PASTE
  } dphase_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  terminal_input_key_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // events still owed by the decoder, oldest first
  out_t pending_events[$];
  int errors = 0;
  int requests_sent = 0;
  int events_seen = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;

  // ---------------------------------------------------------------
  // Decoder predictor state
  // ---------------------------------------------------------------
  dphase_t   dp_phase;
  logic [7:0] dp_held[6];
  int        dp_held_n;
  int        dp_utf_len;
  logic [31:0] dp_pval[2];
  logic [2:0]  dp_pflag[2];
  int        dp_pidx;
  int        dp_p200;
  int        dp_pem;
  out_t      step_events[$];

  function automatic logic [7:0] end_seq_byte(input int k);
    case (k)
      0: return 8'h1b;
      1: return "[";
      2: return "2";
      3: return "0";
      4: return "1";
      default: return "~";
    endcase
  endfunction

  function automatic void push_event(input logic [2:0] kind, input logic [3:0] key,
                                     input logic [3:0] fn, input logic [3:0] mods,
                                     input logic [31:0] text, input logic [2:0] len);
    out_t e;
    if (step_events.size() >= 6) return;
    e.event_kind = kind;
    e.key_code = key;
    e.fkey_num = fn;
    e.modifiers = mods;
    e.text_bytes = text;
    e.text_length = len;
    e.last = 1'b0;
    step_events = {step_events, e};
  endfunction

  function automatic int cursor_key(input logic [7:0] b);
    case (b)
      "A": return 0;
      "B": return 1;
      "C": return 2;
      "D": return 3;
      "H": return 4;
      "F": return 5;
      default: return -1;
    endcase
  endfunction

  function automatic logic [31:0] param_get(input int i);
    return (dp_pflag[i] == 3'd1) ? dp_pval[i] : 32'd0;
  endfunction

  function automatic void csi_param_byte(input logic [7:0] c);
    int i;
    logic [63:0] v;
    i = dp_pidx;
    // body "200" marks a paste start
    if (dp_p200 < 3 && c == ((dp_p200 == 0) ? "2" : "0")) dp_p200++;
    else dp_p200 = P200_FAIL;
    if (c == ";") begin
      if (dp_pidx < 2) dp_pidx++;
      return;
    end
    if (i >= 2) return;
    if (c >= "0" && c <= "9") begin
      v = 64'(dp_pval[i]) * 10 + 64'(c - "0");
      dp_pflag[i] |= 3'd1;
      if (v > 64'h7fffffff) dp_pflag[i] |= 3'd2;
      else dp_pval[i] = v[31:0];
    end else begin
      dp_pflag[i] |= 3'd2;
    end
  endfunction

  function automatic void csi_finish(input logic [7:0] f);
    logic [31:0] first, s;
    logic [3:0] mods;
    int cc;
    first = param_get(0);
    mods = 4'd0;
    dp_phase = DP_IDLE;
    if (dp_p200 == 3 && f == "~") begin
      dp_phase = DP_PASTE;
      dp_pem = 0;
      return;
    end
    if (dp_pidx >= 1) begin
      s = param_get(1);
      if (s > 1) mods = 4'(s - 1);
    end
    if (f == "~") begin
      case (first)
        1, 7: push_event(KIND_KEY, K_HOME, 0, mods, 0, 0);
        2: push_event(KIND_KEY, K_INSERT, 0, mods, 0, 0);
        3: push_event(KIND_KEY, K_DELETE, 0, mods, 0, 0);
        4, 8: push_event(KIND_KEY, K_END, 0, mods, 0, 0);
        5: push_event(KIND_KEY, K_PGUP, 0, mods, 0, 0);
        6: push_event(KIND_KEY, K_PGDN, 0, mods, 0, 0);
        11, 12, 13, 14, 15: push_event(KIND_KEY, K_FUNC, 4'(first - 10), mods, 0, 0);
        17, 18, 19, 20, 21: push_event(KIND_KEY, K_FUNC, 4'(first - 11), mods, 0, 0);
        23, 24: push_event(KIND_KEY, K_FUNC, 4'(first - 12), mods, 0, 0);
        default: push_event(KIND_UNKNOWN, 0, 0, 0, {24'd0, f}, 1);
      endcase
      return;
    end
    cc = cursor_key(f);
    if (cc >= 0) push_event(KIND_KEY, 4'(cc), 0, mods, 0, 0);
    else push_event(KIND_UNKNOWN, 0, 0, 0, {24'd0, f}, 1);
  endfunction

  function automatic void idle_decode(input logic [7:0] b);
    int n;
    if (b == CH_ESC) begin
      dp_phase = DP_ESC;
    end else if (b == 8'h0d || b == 8'h0a) begin
      push_event(KIND_KEY, K_ENTER, 0, 0, 0, 0);
    end else if (b == 8'h09) begin
      push_event(KIND_KEY, K_TAB, 0, 0, 0, 0);
    end else if (b == 8'h7f || b == 8'h08) begin
      push_event(KIND_KEY, K_BKSP, 0, 0, 0, 0);
    end else if (b >= 1 && b <= 26) begin
      push_event(KIND_CHAR, 0, 0, M_CTRL, 32'("a" + b - 1), 1);
    end else if (!b[7]) begin
      push_event(KIND_CHAR, 0, 0, 0, {24'd0, b}, 1);
    end else begin
      n = 0;
      if (b[7:5] == 3'b110) n = 2;
      else if (b[7:4] == 4'b1110) n = 3;
      else if (b[7:3] == 5'b11110) n = 4;
      if (n == 0) begin
        push_event(KIND_INVALID, 0, 0, 0, {24'd0, b}, 1);
        return;
      end
      dp_held[0] = b;
      dp_held_n = 1;
      dp_utf_len = n;
      dp_phase = DP_UTF8;
    end
  endfunction

  function automatic void paste_decode(input logic [7:0] b);
    int m;
    m = (dp_pem > 5) ? 0 : dp_pem;
    if (b == end_seq_byte(m)) begin
      m++;
      if (m == 6) begin
        push_event(KIND_PASTE_END, 0, 0, 0, 0, 0);
        dp_phase = DP_IDLE;
        m = 0;
      end
      dp_pem = m;
      return;
    end
    for (int i = 0; i < m; i++) push_event(KIND_PASTE, 0, 0, 0, {24'd0, end_seq_byte(i)}, 1);
    if (b == CH_ESC) begin
      dp_pem = 1;
    end else begin
      push_event(KIND_PASTE, 0, 0, 0, {24'd0, b}, 1);
      dp_pem = 0;
    end
  endfunction

  // one byte in the current phase; a bad UTF-8 tail is decoded again byte by byte
  function automatic void decode_byte(input logic [7:0] b);
    int cc;
    logic [7:0] tail[3];
    logic [31:0] text;
    bit ok;
    int n;
    case (dp_phase)
      DP_ESC: begin
        dp_phase = DP_IDLE;
        if (b == "[") begin
          dp_phase = DP_CSI;
          dp_pval[0] = 0; dp_pval[1] = 0;
          dp_pflag[0] = 0; dp_pflag[1] = 0;
          dp_pidx = 0;
          dp_p200 = 0;
        end else if (b == "O") begin
          dp_phase = DP_SS3;
        end else if (b >= 8'h20 && b <= 8'h7e) begin
          push_event(KIND_CHAR, 0, 0, M_ALT, {24'd0, b}, 1);
        end else begin
          push_event(KIND_UNKNOWN, 0, 0, 0, {24'd0, b}, 1);
        end
      end
      DP_CSI: begin
        if (b >= 8'h40 && b <= 8'h7e) csi_finish(b);
        else csi_param_byte(b);
      end
      DP_SS3: begin
        dp_phase = DP_IDLE;
        cc = cursor_key(b);
        if (cc >= 0) push_event(KIND_KEY, 4'(cc), 0, 0, 0, 0);
        else if (b >= "P" && b <= "S") push_event(KIND_KEY, K_FUNC, 4'(b - "P" + 1), 0, 0, 0);
        else push_event(KIND_UNKNOWN, 0, 0, 0, {24'd0, b}, 1);
      end
      DP_UTF8: begin
        n = dp_utf_len;
        dp_held[dp_held_n] = b;
        dp_held_n++;
        if (dp_held_n < n) return;
        ok = 1'b1;
        for (int i = 1; i < n; i++) if (dp_held[i][7:6] != 2'b10) ok = 1'b0;
        dp_phase = DP_IDLE;
        dp_held_n = 0;
        if (ok) begin
          text = 0;
          for (int i = 0; i < n; i++) text |= 32'(dp_held[i]) << (8 * i);
          push_event(KIND_CHAR, 0, 0, 0, text, 3'(n));
          return;
        end
        push_event(KIND_INVALID, 0, 0, 0, {24'd0, dp_held[0]}, 1);
        for (int i = 1; i < n; i++) tail[i-1] = dp_held[i];
        for (int i = 0; i + 1 < n; i++) decode_byte(tail[i]);
      end
      DP_PASTE: paste_decode(b);
      default: begin
        dp_phase = DP_IDLE;
        idle_decode(b);
      end
    endcase
  endfunction

  function automatic void predict_request(input in_t req);
    step_events.delete();
    if (req.operation == OP_TICK) begin
      if (dp_phase == DP_ESC) begin
        dp_phase = DP_IDLE;
        push_event(KIND_KEY, K_ESCAPE, 0, 0, 0, 0);
      end
    end else begin
      decode_byte(req.byte_in);
    end
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[i]) pending_events = {pending_events, step_events[i]};
  endfunction

  // ---------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------
  task automatic send_request(input logic op, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no gap
    repeat (gap) @(negedge clk);
    in_data.operation = op;
    in_data.byte_in = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(in_data);
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_bytes(input string s);
    for (int i = 0; i < s.len(); i++) send_request(OP_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // ---------------------------------------------------------------
  // Result checker and ready staller
  // ---------------------------------------------------------------
  // ready is raised after a random stall and dropped after each event is taken
  initial begin : rx_stall
    int w;
    @(posedge rst_n);
    forever begin
      w = $urandom_range(0, 9);
      repeat (w) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      out_ready = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (out_data.event_kind !== want.event_kind ||
            out_data.key_code !== want.key_code ||
            out_data.fkey_num !== want.fkey_num ||
            out_data.modifiers !== want.modifiers ||
            out_data.text_bytes !== want.text_bytes ||
            out_data.text_length !== want.text_length ||
            out_data.last !== want.last) begin
          $display("%0t: event mismatch, expected %h, actual %h", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (stimulus_done && pending_events.size() == 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d events outstanding", $time, pending_events.size());
      $display("** terminal_input_key_decoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_plain_and_control();
    logic [7:0] ctl[12] = '{8'h00, 8'h01, 8'h1a, 8'h1c, 8'h1f, 8'h0d, 8'h0a, 8'h09,
                            8'h7f, 8'h08, 8'h20, 8'h7e};
    foreach (ctl[i]) send_request(OP_BYTE, ctl[i]);
    send_request(OP_BYTE, 8'hff);       // bad lead byte
    send_request(OP_TICK, 8'h00);       // tick with no ESC held
  endtask

  task automatic test_escape_forms();
    send_request(OP_BYTE, CH_ESC); send_request(OP_TICK, 8'hff);   // lone escape
    send_request(OP_BYTE, CH_ESC); send_request(OP_BYTE, "x");     // alt char
    send_request(OP_BYTE, CH_ESC); send_request(OP_BYTE, CH_ESC);  // esc esc
    send_request(OP_BYTE, CH_ESC); send_request(OP_BYTE, 8'h7f);
    send_bytes("\033OA"); send_bytes("\033OS"); send_bytes("\033Oz");
    send_bytes("\033[1;5C"); send_bytes("\033[24;16~"); send_bytes("\033[99~");
    send_bytes("\033[-3~"); send_bytes("\033[3000000000~"); send_bytes("\033[;;;Z");
    send_bytes("\033[1;2;3D");
  endtask

  task automatic test_utf8();
    send_bytes("\xc3\xa9"); send_bytes("\xe2\x82\xac"); send_bytes("\xf0\x9f\x98\x80");
    send_bytes("\xe2\x1b[A");           // bad tail replays an escape sequence
    send_bytes("\xf0abc");
  endtask

  task automatic test_paste();
    send_bytes("\033[200~hi\033[20x\033\033[201~");
  endtask

  task automatic test_random_streams();
    int kind;
    logic [7:0] b;
    for (int n = 0; n < 25; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: send_request(OP_BYTE, 8'($urandom));
        1: send_request(OP_TICK, 8'($urandom));
        2: begin
          send_request(OP_BYTE, CH_ESC);
          if ($urandom_range(0, 1)) send_request(OP_TICK, 8'($urandom));
          else send_request(OP_BYTE, 8'($urandom));
        end
        3, 4: begin
          send_bytes("\033[");
          if ($urandom_range(0, 2)) send_bytes($sformatf("%0d", $urandom_range(1, 24)));
          if ($urandom_range(0, 1)) send_bytes($sformatf(";%0d", $urandom_range(0, 17)));
          if ($urandom_range(0, 4) == 0) send_request(OP_BYTE, 8'($urandom_range(0, 63)));
          b = $urandom_range(0, 1) ? "~" : 8'($urandom_range(8'h40, 8'h7e));
          send_request(OP_BYTE, b);
        end
        5: begin
          send_bytes("\033O");
          send_request(OP_BYTE, 8'($urandom));
        end
        6: begin
          b = 8'hc0 | 8'($urandom_range(0, 47));
          send_request(OP_BYTE, b);
          repeat ($urandom_range(1, 3))
            send_request(OP_BYTE, $urandom_range(0, 3) ? (8'h80 | 8'($urandom_range(0, 63)))
                                                       : 8'($urandom));
        end
        7: begin
          send_bytes("\033[200~");
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) send_bytes("\033[20");
            send_request(OP_BYTE, 8'($urandom));
          end
          send_bytes("\033[201~");
        end
        default: send_request(OP_BYTE, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
      if (n == 12) wait_drained();      // hold off until decoder empties
    end
  endtask

  initial begin
    dp_phase = DP_IDLE;
    dp_held_n = 0; dp_utf_len = 0;
    dp_pval[0] = 0; dp_pval[1] = 0; dp_pflag[0] = 0; dp_pflag[1] = 0;
    dp_pidx = 0; dp_p200 = 0; dp_pem = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_plain_and_control();
    test_escape_forms();
    test_utf8();
    test_paste();
    wait_drained();
    test_random_streams();
    // leave the decoder idle so nothing stays held
    send_bytes("\033[201~");
    send_request(OP_TICK, 8'h00);
    stimulus_done = 1'b1;
    wait_drained();
    $display("Sent %0d requests (control, escape, CSI/SS3, UTF-8, paste, ticks);", requests_sent);
    $display("checked %0d decoded events.", events_seen);
    if (errors == 0) begin
      $display("** terminal_input_key_decoder: PASSED **");
    end else begin
      $display("** terminal_input_key_decoder: FAILED **");
    end
    $finish;
  end

endmodule
